FILE: rtl/depth_minmax_to_gray_macros.svh
// Assertion macros shared by the depth-to-gray RTL.
`ifndef DEPTH_MINMAX_TO_GRAY_MACROS_SVH
`define DEPTH_MINMAX_TO_GRAY_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define DMG_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("depth_minmax_to_gray: same-cycle check failed");

// Check that a condition implies a consequence in the next cycle.
`define DMG_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("depth_minmax_to_gray: next-cycle check failed");

`endif

FILE: rtl/dmg_pkg.sv
// Shared types and constants for the depth-to-gray block.
`timescale 1ns / 1ps
package dmg_pkg;

   localparam int DEPTH_W            = 24;
   localparam int GRAY_W             = 8;
   localparam int DEPTH_BITS_DEFAULT = 24;
   localparam int DIV_STEPS          = GRAY_W;
   localparam int CNT_W              = $clog2(DIV_STEPS);

   localparam logic [GRAY_W-1:0] GRAY_FULL = 8'hFF;
   localparam logic [GRAY_W-1:0] GRAY_ZERO = 8'h00;

   localparam logic KIND_SCAN    = 1'b0;
   localparam logic KIND_CONVERT = 1'b1;

   typedef struct packed {
      logic               kind;
      logic [DEPTH_W-1:0] depth;
      logic               first_sample;
   } req_type;

   typedef struct packed {
      logic [GRAY_W-1:0] gray;
      logic              flat_range;
   } rsp_type;

   typedef struct packed {
      logic scan_upd;
      logic capture;
      logic prep;
      logic div_step;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic short_case;
   } sts_type;

endpackage

FILE: rtl/dmg_ctrl.sv
// Sequencer for the depth-to-gray block: handshakes, divide step count, output valid.
`timescale 1ns / 1ps
`include "depth_minmax_to_gray_macros.svh"
module dmg_ctrl
   import dmg_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_kind,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output cmd_type cmd,
   input  sts_type sts
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_PREP = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_FIN  = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             valid_ff, valid_in;
   logic             accept;
   logic             out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !valid_ff || !rsp_stall;
   assign rsp_valid = valid_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd          = '0;
      cmd.scan_upd = accept && (req_kind == KIND_SCAN);
      cmd.capture  = accept && (req_kind == KIND_CONVERT);
      case (state_ff)
         ST_IDLE: begin
            if (cmd.capture) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            cnt_in   = CNT_W'(DIV_STEPS - 1);
            state_in = sts.short_case ? ST_FIN : ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.load_out) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   `DMG_ASSERT_NEXT(a_convert_enters_prep, clock, reset, cmd.capture, state_ff == ST_PREP)
   `DMG_ASSERT_NEXT(a_last_step_finishes, clock, reset,
      (state_ff == ST_DIV) && (cnt_ff == '0), state_ff == ST_FIN)
   `DMG_ASSERT_NEXT(a_load_raises_valid, clock, reset, cmd.load_out,
      valid_ff && (state_ff == ST_IDLE))

endmodule

FILE: rtl/dmg_datapath.sv
// Datapath: running extremes, operand prep, restoring divider and output register.
`timescale 1ns / 1ps
`include "depth_minmax_to_gray_macros.svh"
module dmg_datapath
   import dmg_pkg::*;
#(
   parameter int DEPTH_BITS = DEPTH_BITS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  req_type req_data,
   input  cmd_type cmd,
   output sts_type sts,
   output rsp_type rsp_data
);

   localparam int W = DEPTH_BITS + GRAY_W;

   logic [DEPTH_BITS-1:0] min_ff, min_in;
   logic [DEPTH_BITS-1:0] max_ff, max_in;
   logic [DEPTH_BITS-1:0] depth_ff;
   logic [DEPTH_BITS-1:0] d_new;
   logic [DEPTH_BITS-1:0] diff;
   logic [DEPTH_BITS-1:0] range;
   logic [W-1:0]          num;
   logic [W-1:0]          rem_ff, rem_in;
   logic [W-1:0]          dsh_ff, dsh_in;
   logic [GRAY_W-1:0]     quo_ff, quo_in;
   logic                  flat_ff, low_ff, high_ff;
   logic                  flat, low, high;
   logic                  ge;
   rsp_type               out_ff;

   // drop depth bits above the configured width
   assign d_new = DEPTH_BITS'(req_data.depth);

   always_comb begin
      min_in = min_ff;
      max_in = max_ff;
      if (cmd.scan_upd) begin
         if (req_data.first_sample) begin
            min_in = d_new;
            max_in = d_new;
         end else begin
            if (d_new < min_ff) begin
               min_in = d_new;
            end
            if (d_new > max_ff) begin
               max_in = d_new;
            end
         end
      end
   end

   assign flat  = (max_ff <= min_ff);
   assign low   = (depth_ff <= min_ff);
   assign high  = (depth_ff >= max_ff);
   assign diff  = depth_ff - min_ff;
   assign range = max_ff - min_ff;
   // 255 * diff as (diff << 8) - diff
   assign num   = (W'(diff) << GRAY_W) - W'(diff);

   assign sts.short_case = flat || low || high;

   assign ge = (rem_ff >= dsh_ff);

   always_comb begin
      rem_in = rem_ff;
      dsh_in = dsh_ff;
      quo_in = quo_ff;
      if (cmd.prep) begin
         rem_in = num;
         dsh_in = W'(range) << (GRAY_W - 1);
         quo_in = GRAY_ZERO;
      end else if (cmd.div_step) begin
         if (ge) begin
            rem_in = rem_ff - dsh_ff;
         end
         dsh_in = dsh_ff >> 1;
         quo_in = {quo_ff[GRAY_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= '1;
         max_ff <= '0;
      end else begin
         min_ff <= min_in;
         max_ff <= max_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         depth_ff <= d_new;
      end
      if (cmd.prep) begin
         flat_ff <= flat;
         low_ff  <= low;
         high_ff <= high;
      end
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
      if (cmd.load_out) begin
         out_ff.flat_range <= flat_ff;
         if (flat_ff || low_ff) begin
            out_ff.gray <= GRAY_ZERO;
         end else if (high_ff) begin
            out_ff.gray <= GRAY_FULL;
         end else begin
            out_ff.gray <= quo_ff;
         end
      end
   end

   assign rsp_data = out_ff;

   `DMG_ASSERT_NEXT(a_first_sets_both, clock, reset,
      cmd.scan_upd && req_data.first_sample, min_ff == max_ff)
   `DMG_ASSERT_NEXT(a_flat_gives_zero, clock, reset,
      cmd.load_out && flat_ff, rsp_data.flat_range && (rsp_data.gray == GRAY_ZERO))

endmodule

FILE: rtl/depth_minmax_to_gray.sv
// Top level of the depth-to-gray min-max normalizer.
// Maps depth samples to 8-bit gray by min-max normalization. Stream each frame
// twice: first as scan requests (kind 0), which update the running minimum and
// maximum and return nothing (first_sample restarts both extremes), then as
// convert requests (kind 1), each returning one result with
// gray = floor(255 * (depth - min) / (max - min)), clamped to 0..255. When
// max <= min (including convert before any scan) gray is 0 and flat_range is 1.
// Only the low DEPTH_BITS bits of depth are used. A convert request runs
// capture, operand prep, eight iterations of the shared restoring divider (one
// quotient bit per cycle), and output load; samples at or beyond the extremes
// or on a flat range skip the divider. The divider's one-bit-per-cycle loop,
// together with any stall on the output, sets the convert rate. A finished
// result sits in the output register while the next request is accepted and
// worked on.
`timescale 1ns / 1ps
module depth_minmax_to_gray
   import dmg_pkg::*;
#(
   parameter int DEPTH_BITS = DEPTH_BITS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // command and status between sequencer and datapath
   cmd_type cmd;
   sts_type sts;

   // sequencer: accept requests, step the divider, hold the output valid
   dmg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_data.kind),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   // datapath: extremes, divide operands, quotient and output register
   dmg_datapath #(
      .DEPTH_BITS (DEPTH_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule
